// File: src/smbios_pkg.sv
// shared types and constants for the smbios structure table framer
// no dependencies; imported by smbios_walk and the top level
package smbios_pkg;

    localparam int unsigned TABLE_W  = 16;
    localparam int unsigned MIN_HDR  = 4;
    localparam int unsigned APB_AW   = 3;
    localparam int unsigned APB_DW   = 32;

    // register indexes on the configuration port
    localparam logic REG_TABLE_LENGTH    = 1'b0;
    localparam logic REG_STRUCTURE_COUNT = 1'b1;

    typedef enum logic [2:0] {
        ROLE_TYPE       = 3'd0,
        ROLE_LENGTH     = 3'd1,
        ROLE_HANDLE     = 3'd2,
        ROLE_FORMATTED  = 3'd3,
        ROLE_STRING     = 3'd4,
        ROLE_STRING_END = 3'd5,
        ROLE_FINAL_ZERO = 3'd6,
        ROLE_IGNORED    = 3'd7
    } byte_role_t;

    typedef struct packed {
        logic [TABLE_W-1:0] table_length;
        logic [TABLE_W-1:0] structure_count;
    } cfg_t;

    typedef struct packed {
        logic [TABLE_W-1:0] structure_index;
        byte_role_t         byte_role;
        logic [7:0]         structure_type;
        logic [TABLE_W-1:0] offset_in_structure;
        logic [7:0]         string_number;
        logic               structure_complete;
        logic               structure_truncated;
        logic               table_done;
    } result_t;

endpackage

// File: src/smbios_walk.sv
// walk state and per-byte classification of the structure table
// depends on smbios_pkg; state advances on every accepted byte
module smbios_walk import smbios_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        accept,
    input  logic [7:0]  table_byte,
    input  logic        start_of_table,
    input  cfg_t        cfg,
    output result_t     result
);

    logic [TABLE_W-1:0] pos_reg, pos_next;
    logic [TABLE_W-1:0] seen_reg, seen_next;
    logic [TABLE_W-1:0] start_reg, start_next;
    logic [7:0]         flen_reg, flen_next;
    logic [7:0]         type_reg, type_next;
    logic [7:0]         str_reg, str_next;
    logic               pz_reg, pz_next;
    logic               active_reg, active_next;

    logic [TABLE_W-1:0] pos, seen, start;
    logic [7:0]         flen, ctype, cstr;
    logic               pz, active;
    logic [TABLE_W-1:0] off;
    logic [TABLE_W:0]   pos_ext, pos_plus1, pos_plus5, len_ext, next_seen;
    logic               ends;

    always_comb begin
        // start of table restarts from a cleared state
        pos    = start_of_table ? '0 : pos_reg;
        seen   = start_of_table ? '0 : seen_reg;
        start  = start_of_table ? '0 : start_reg;
        flen   = start_of_table ? '0 : flen_reg;
        ctype  = start_of_table ? '0 : type_reg;
        cstr   = start_of_table ? '0 : str_reg;
        pz     = start_of_table ? 1'b0 : pz_reg;
        active = start_of_table
            ? ((cfg.structure_count != '0) && (cfg.table_length >= TABLE_W'(MIN_HDR)))
            : active_reg;

        off       = pos - start;
        pos_ext   = {1'b0, pos};
        pos_plus1 = pos_ext + (TABLE_W+1)'(1);
        pos_plus5 = pos_ext + (TABLE_W+1)'(5);
        len_ext   = {1'b0, cfg.table_length};
        next_seen = {1'b0, seen} + (TABLE_W+1)'(1);
        ends      = 1'b0;

        result      = '0;
        pos_next    = pos;
        seen_next   = seen;
        start_next  = start;
        flen_next   = flen;
        type_next   = ctype;
        str_next    = cstr;
        pz_next     = pz;
        active_next = active;

        if (!active) begin
            result.byte_role  = ROLE_IGNORED;
            result.table_done = start_of_table;
        end else begin
            if (off == '0) begin
                type_next        = table_byte;
                flen_next        = '0;
                str_next         = '0;
                pz_next          = 1'b0;
                result.byte_role = ROLE_TYPE;
            end else if (off == TABLE_W'(1)) begin
                flen_next        = (table_byte < 8'(MIN_HDR)) ? 8'(MIN_HDR) : table_byte;
                result.byte_role = ROLE_LENGTH;
            end else if (off < TABLE_W'(MIN_HDR)) begin
                result.byte_role = ROLE_HANDLE;
            end else if (off < {8'd0, flen}) begin
                result.byte_role = ROLE_FORMATTED;
            end else begin
                // string area: entering it resets the string counter
                if (off == {8'd0, flen}) begin
                    str_next = 8'd1;
                    pz_next  = 1'b0;
                end
                if (table_byte == 8'd0) begin
                    if (pz_next) begin
                        result.byte_role = ROLE_FINAL_ZERO;
                        ends             = 1'b1;
                    end else begin
                        result.byte_role     = ROLE_STRING_END;
                        result.string_number = str_next;
                        pz_next              = 1'b1;
                        if (str_next != 8'hff) begin
                            str_next = str_next + 8'd1;
                        end
                    end
                end else begin
                    result.byte_role     = ROLE_STRING;
                    result.string_number = str_next;
                    pz_next              = 1'b0;
                end
            end

            result.structure_index     = seen;
            result.structure_type      = type_next;
            result.offset_in_structure = off;

            if (ends) begin
                result.structure_complete = 1'b1;
                seen_next = next_seen[TABLE_W-1:0];
                if ((next_seen < {1'b0, cfg.structure_count}) && (pos_plus5 <= len_ext)) begin
                    start_next = pos_plus1[TABLE_W-1:0];
                end else begin
                    result.table_done = 1'b1;
                    active_next       = 1'b0;
                end
            end else if (pos_plus1 >= len_ext) begin
                result.structure_truncated = 1'b1;
                result.table_done          = 1'b1;
                active_next                = 1'b0;
            end
            pos_next = pos_plus1[TABLE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            seen_reg   <= '0;
            start_reg  <= '0;
            flen_reg   <= '0;
            type_reg   <= '0;
            str_reg    <= '0;
            pz_reg     <= 1'b0;
            active_reg <= 1'b0;
        end else if (accept) begin
            pos_reg    <= pos_next;
            seen_reg   <= seen_next;
            start_reg  <= start_next;
            flen_reg   <= flen_next;
            type_reg   <= type_next;
            str_reg    <= str_next;
            pz_reg     <= pz_next;
            active_reg <= active_next;
        end
    end

endmodule

// File: src/smbios_structure_table_framer.sv
// smbios structure table framer: top level with apb registers and output stage
// depends on smbios_pkg and smbios_walk
//
// usage: table bytes enter one per transaction on the s_ channel, s_tdata the
// byte and s_tuser set on the first byte of a walk. every input transaction
// gives exactly one result transaction on the m_ channel telling the byte's
// role, structure index, type, offset and string number.
// table_length and structure_count are written over apb at 0x0 and 0x4 while
// the stream is idle; reads return the stored values.
// the result is registered and presented in the cycle after the byte is accepted.
// throughput: one byte per cycle while the output is not stalled; the walk state and
// the result register update in the same cycle, so bytes can arrive back to back.
// when m_tready is low the result holds in the output register and s_tready
// drops until it is taken; a byte is still accepted in the cycle the held
// result leaves.
// reset (aresetn low, synchronous) clears the registers, the walk state and
// the output valid; the block then ignores bytes until a start of table.
module smbios_structure_table_framer import smbios_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] table_byte
    input  logic              s_tuser,   // [0] start_of_table
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [47:0]       m_tdata,   // [15:0] structure_index, [23:16] structure_type,
                                         // [39:24] offset_in_structure, [47:40] string_number
    output logic [4:0]        m_tuser,   // [2:0] byte_role, [3] structure_complete,
                                         // [4] structure_truncated
    output logic              m_tlast,   // table_done
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    cfg_t    cfg_reg;
    result_t result;
    result_t out_reg;
    logic    out_valid_reg;
    logic    accept;
    logic    cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        unique case (paddr[2])
            REG_TABLE_LENGTH:    prdata = {16'd0, cfg_reg.table_length};
            REG_STRUCTURE_COUNT: prdata = {16'd0, cfg_reg.structure_count};
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_TABLE_LENGTH:    cfg_reg.table_length    <= pwdata[TABLE_W-1:0];
                REG_STRUCTURE_COUNT: cfg_reg.structure_count <= pwdata[TABLE_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    smbios_walk u_walk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (accept),
        .table_byte     (s_tdata),
        .start_of_table (s_tuser),
        .cfg            (cfg_reg),
        .result         (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.string_number, out_reg.offset_in_structure,
                       out_reg.structure_type, out_reg.structure_index};
    assign m_tuser  = {out_reg.structure_truncated, out_reg.structure_complete,
                       out_reg.byte_role};
    assign m_tlast  = out_reg.table_done;

endmodule

// File: tb/smbios_structure_table_framer_test.sv
// self-checking testbench for the smbios structure table framer
// needs smbios_pkg and the smbios_structure_table_framer rtl; predicts every byte report
// on its own and compares it with the m_ stream, configuring the block over apb
`timescale 1ns / 100ps

module smbios_structure_table_framer_test import smbios_pkg::*; ();

    typedef struct packed {
        logic [7:0] value;
        logic       sot;
    } table_item_t;

    logic              aclk;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata  = 8'h00;
    logic              s_tuser  = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [47:0]       m_tdata;
    logic [4:0]        m_tuser;
    logic              m_tlast;
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [APB_AW-1:0] paddr    = '0;
    logic [APB_DW-1:0] pwdata   = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    smbios_structure_table_framer i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #3_000_000;
        $display("== FAIL ==");
        $finish;
    end

    table_item_t pending_bytes[$];
    table_item_t table_draft[$];
    result_t     byte_reports_due[$];
    int          fail_count = 0;

    // shadow copy of the registers and the walk
    logic [15:0] cfg_length = '0;
    logic [15:0] cfg_count  = '0;
    logic [15:0] walk_pos   = '0;
    logic [15:0] walk_seen  = '0;
    logic [15:0] walk_start = '0;
    logic [7:0]  walk_fmt   = '0;
    logic [7:0]  walk_type  = '0;
    logic [7:0]  walk_str   = '0;
    logic        walk_zero  = 1'b0;
    logic        walk_on    = 1'b0;

    function automatic result_t classify_table_byte(input logic [7:0] tb, input logic sot);
        result_t     r;
        int unsigned pos;
        int unsigned off;
        int unsigned next_seen;
        logic        closes;
        r = '0;
        closes = 1'b0;
        if (sot) begin
            walk_pos   = '0;
            walk_seen  = '0;
            walk_start = '0;
            walk_fmt   = '0;
            walk_type  = '0;
            walk_str   = '0;
            walk_zero  = 1'b0;
            walk_on    = (cfg_count != 0) && (cfg_length >= MIN_HDR);
            if (!walk_on) begin
                r.byte_role  = ROLE_IGNORED;
                r.table_done = 1'b1;
                return r;
            end
        end else if (!walk_on) begin
            r.byte_role = ROLE_IGNORED;
            return r;
        end
        pos = walk_pos;
        off = (pos - walk_start) & 32'hFFFF;
        if (off == 0) begin
            walk_type   = tb;
            walk_fmt    = '0;
            walk_str    = '0;
            walk_zero   = 1'b0;
            r.byte_role = ROLE_TYPE;
        end else if (off == 1) begin
            walk_fmt    = (tb < MIN_HDR) ? 8'(MIN_HDR) : tb;
            r.byte_role = ROLE_LENGTH;
        end else if (off < MIN_HDR) begin
            r.byte_role = ROLE_HANDLE;
        end else if (off < walk_fmt) begin
            r.byte_role = ROLE_FORMATTED;
        end else begin
            // first byte past the formatted area opens string one
            if (off == walk_fmt) begin
                walk_str  = 8'd1;
                walk_zero = 1'b0;
            end
            if (tb == 0) begin
                if (walk_zero) begin
                    r.byte_role = ROLE_FINAL_ZERO;
                    closes = 1'b1;
                end else begin
                    r.byte_role     = ROLE_STRING_END;
                    r.string_number = walk_str;
                    walk_zero = 1'b1;
                    if (walk_str != 8'hFF) walk_str = walk_str + 8'd1;
                end
            end else begin
                r.byte_role     = ROLE_STRING;
                r.string_number = walk_str;
                walk_zero = 1'b0;
            end
        end
        r.structure_index     = walk_seen;
        r.structure_type      = walk_type;
        r.offset_in_structure = off[15:0];
        if (closes) begin
            r.structure_complete = 1'b1;
            next_seen = walk_seen + 1;
            if (next_seen < cfg_count && pos + 5 <= cfg_length) begin
                walk_start = 16'(pos + 1);
            end else begin
                r.table_done = 1'b1;
                walk_on = 1'b0;
            end
            walk_seen = next_seen[15:0];
        end else if (pos + 1 >= cfg_length) begin
            r.structure_truncated = 1'b1;
            r.table_done          = 1'b1;
            walk_on = 1'b0;
        end
        walk_pos = 16'(pos + 1);
        return r;
    endfunction

    // sender: bursts of random length, random gaps between them
    int          burst_left = 1;
    int          gap_left   = 0;
    table_item_t next_byte;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                byte_reports_due.push_back(classify_table_byte(s_tdata, s_tuser));
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_bytes.size() != 0) begin
                    next_byte = pending_bytes.pop_front();
                    s_tdata  <= next_byte.value;
                    s_tuser  <= next_byte.sot;
                    s_tvalid <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: switches between always ready, coin flips and a fixed stall pattern
    int rx_mode  = 0;
    int rx_left  = 0;
    int rx_phase = 0;

    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 2);
            rx_left <= $urandom_range(10, 60);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            0: begin
                m_tready <= 1'b1;
            end
            1: begin
                m_tready <= 1'($urandom_range(0, 1));
            end
            default: begin
                m_tready <= (rx_phase % 7) >= 3;
            end
        endcase
        rx_phase <= rx_phase + 1;
    end

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    result_t due;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (byte_reports_due.size() == 0) begin
                $error("result transaction with no byte report pending");
                fail_count++;
            end else begin
                due = byte_reports_due.pop_front();
                check_field("structure_index", due.structure_index, m_tdata[15:0]);
                check_field("structure_type", due.structure_type, m_tdata[23:16]);
                check_field("offset_in_structure", due.offset_in_structure, m_tdata[39:24]);
                check_field("string_number", due.string_number, m_tdata[47:40]);
                check_field("byte_role", due.byte_role, m_tuser[2:0]);
                check_field("structure_complete", due.structure_complete, m_tuser[3]);
                check_field("structure_truncated", due.structure_truncated, m_tuser[4]);
                check_field("table_done", due.table_done, m_tlast);
            end
        end
    end

    task automatic apb_access(input logic idx, input logic wr, input logic [15:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'h0000, data};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (!wr && prdata[15:0] !== data) begin
            $error("register %0d: expected %0d, got %0d", idx, data, prdata[15:0]);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_bytes.size() != 0 || s_tvalid || byte_reports_due.size() != 0)
            @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic load_phase(input int t_len, input int t_cnt);
        wait_idle();
        apb_access(REG_TABLE_LENGTH, 1'b1, 16'(t_len));
        apb_access(REG_STRUCTURE_COUNT, 1'b1, 16'(t_cnt));
        cfg_length = 16'(t_len);
        cfg_count  = 16'(t_cnt);
        apb_access(REG_TABLE_LENGTH, 1'b0, 16'(t_len));
        apb_access(REG_STRUCTURE_COUNT, 1'b0, 16'(t_cnt));
        foreach (table_draft[i]) pending_bytes.push_back(table_draft[i]);
        table_draft.delete();
    endtask

    task automatic draft_byte(input int v, input logic sot);
        table_draft.push_back('{value: 8'(v), sot: sot});
    endtask

    task automatic draft_structure(input logic first);
        int sel;
        int fmt_byte;
        int n_str;
        int n_chr;
        sel = $urandom_range(0, 19);
        if (sel < 3) fmt_byte = $urandom_range(0, 3);
        else if (sel < 6) fmt_byte = $urandom_range(13, 40);
        else fmt_byte = $urandom_range(4, 12);
        draft_byte($urandom_range(0, 255), first);
        draft_byte(fmt_byte, 1'b0);
        draft_byte($urandom_range(0, 255), 1'b0);
        draft_byte($urandom_range(0, 255), 1'b0);
        // zeros in the formatted area must not close the structure
        repeat ((fmt_byte < MIN_HDR) ? 0 : fmt_byte - MIN_HDR)
            draft_byte(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 255), 1'b0);
        n_str = $urandom_range(0, 3);
        if (n_str == 0) draft_byte(0, 1'b0);
        repeat (n_str) begin
            n_chr = $urandom_range(1, 5);
            repeat (n_chr) draft_byte($urandom_range(1, 255), 1'b0);
            draft_byte(0, 1'b0);
        end
        draft_byte(0, 1'b0);
    endtask

    task automatic run_wellformed_table(output int n_items);
        int n_struct;
        int real_start;
        int real_len;
        int t_len;
        int t_cnt;
        int sel;
        // sometimes an abandoned walk ahead of the real one
        if ($urandom_range(0, 5) == 0) begin
            draft_byte($urandom_range(0, 255), 1'b1);
            repeat ($urandom_range(0, 5)) draft_byte($urandom_range(0, 255), 1'b0);
        end
        real_start = table_draft.size();
        n_struct = $urandom_range(1, 4);
        for (int i = 0; i < n_struct; i++) draft_structure(i == 0);
        real_len = table_draft.size() - real_start;
        sel = $urandom_range(0, 19);
        if (sel < 10) t_len = real_len;
        else if (sel < 14) t_len = real_len - $urandom_range(1, 5);
        else if (sel < 17) t_len = real_len + $urandom_range(1, 12);
        else if (sel < 19) t_len = 65535;
        else t_len = $urandom_range(0, 3);
        sel = $urandom_range(0, 19);
        if (sel < 12) t_cnt = n_struct;
        else if (sel < 15) t_cnt = n_struct - 1;
        else if (sel < 18) t_cnt = n_struct + $urandom_range(1, 3);
        else t_cnt = 65535;
        n_items = table_draft.size();
        repeat ($urandom_range(0, 3)) draft_byte($urandom_range(0, 255), 1'b0);
        load_phase(t_len, t_cnt);
    endtask

    task automatic run_noise(output int n_items);
        n_items = $urandom_range(10, 40);
        draft_byte($urandom_range(0, 255), 1'b1);
        repeat (n_items - 1)
            draft_byte(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 255),
                       $urandom_range(0, 11) == 0);
        load_phase($urandom_range(0, 40), $urandom_range(0, 4));
    endtask

    int random_done = 0;
    int n_batch;

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // idle byte, then a start with no structures claimed
        draft_byte(8'hFF, 1'b0);
        draft_byte(8'h00, 1'b1);
        load_phase(0, 0);

        // table too short for one header
        draft_byte(8'h11, 1'b1);
        load_phase(3, 5);

        // widest registers: short length byte with empty string area, a formatted zero,
        // then a restart in the middle of a walk
        draft_byte(8'hFF, 1'b1);
        draft_byte(8'h02, 1'b0);
        draft_byte(8'h00, 1'b0);
        draft_byte(8'hFF, 1'b0);
        draft_byte(8'h00, 1'b0);
        draft_byte(8'h00, 1'b0);
        draft_byte(8'h00, 1'b0);
        draft_byte(8'h05, 1'b0);
        draft_byte(8'h34, 1'b0);
        draft_byte(8'h12, 1'b0);
        draft_byte(8'h00, 1'b0);
        draft_byte(8'h41, 1'b0);
        draft_byte(8'h00, 1'b0);
        draft_byte(8'h00, 1'b0);
        draft_byte(8'h7F, 1'b1);
        draft_byte(8'h04, 1'b0);
        draft_byte(8'h01, 1'b0);
        load_phase(65535, 65535);

        // table ends inside the string area
        draft_byte(8'hC3, 1'b1);
        draft_byte(8'h04, 1'b0);
        draft_byte(8'hAA, 1'b0);
        draft_byte(8'h55, 1'b0);
        draft_byte(8'h42, 1'b0);
        draft_byte(8'h43, 1'b0);
        load_phase(6, 2);

        // next header would not fit
        draft_byte(8'h01, 1'b1);
        draft_byte(8'h04, 1'b0);
        repeat (4) draft_byte(8'h00, 1'b0);
        load_phase(9, 3);

        // enough strings to saturate the string number
        draft_byte(8'h08, 1'b1);
        draft_byte(8'h04, 1'b0);
        draft_byte($urandom_range(0, 255), 1'b0);
        draft_byte($urandom_range(0, 255), 1'b0);
        repeat (256) begin
            draft_byte($urandom_range(1, 255), 1'b0);
            draft_byte(0, 1'b0);
        end
        draft_byte(0, 1'b0);
        load_phase(600, 1);

        // the directed tables above already carry most of the byte budget
        while (random_done < 60) begin
            if ($urandom_range(0, 9) < 7) run_wellformed_table(n_batch);
            else run_noise(n_batch);
            random_done += n_batch;
        end

        wait_idle();
        repeat (10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
